### sv/mtrg_pkg.sv
// ---------------------------------------------------------------------------
// mtrg_pkg
// Shared types and codes for the MAC table with resource gauges.
// ---------------------------------------------------------------------------
package mtrg_pkg;

	localparam logic [1:0] KIND_UPDATE = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_FLUSH  = 2'd2;
	localparam logic [1:0] KIND_GAUGE  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// one table row as stored in memory, live flag included
	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic [1:0]  etype;
		logic [15:0] eparam;
		logic [5:0]  rclass;
		logic [7:0]  slots;
	} row_t;

	localparam int ROW_W = $bits(row_t);

endpackage

### sv/mac_table_with_resource_gauges.sv
// ---------------------------------------------------------------------------
// mac_table_with_resource_gauges
// Keyed MAC/FID table with per-resource slot gauges and change counter.
// ---------------------------------------------------------------------------
// Usage: a request enters on the in channel (in_valid / in_stall) and one
// response leaves on the out channel (out_valid / out_stall). The block
// serves one request at a time. Every request sweeps the whole row memory,
// one row per cycle through its read port, and the live flag of each row
// sits in the memory beside the row. The sweep is followed by the apply
// step, and the gauge total is then summed from the gauge registers before
// out_valid rises.
// Reset clears the gauges, the sequence number and the row count, then a
// clearing pass zeroes the row memory; in_stall stays high until it ends.
// The response is held in the output registers while out_stall is high;
// in_stall stays high until the response has been taken and the block is
// back in idle.
// ---------------------------------------------------------------------------
module mac_table_with_resource_gauges #(
	parameter int TABLE_ENTRIES    = 1024,
	parameter int RESOURCE_CLASSES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [47:0] mac_address,
	input  logic [15:0] filter_id,
	input  logic [1:0]  entry_type,
	input  logic [15:0] entry_param,
	input  logic [3:0]  resource_class,
	input  logic [7:0]  slot_count,
	input  logic [2:0]  match_flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] gauge_value,
	output logic [31:0] gauge_total,
	output logic [31:0] sequence_number,
	output logic [10:0] row_count,
	output logic [10:0] removed_count
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = (RESOURCE_CLASSES > 1) ? $clog2(RESOURCE_CLASSES) : 1;
	localparam int NW = $clog2(TABLE_ENTRIES + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DO   = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;
	localparam logic [2:0] S_CLR  = 3'd5;

	logic [2:0] state_q;

	// request registers
	logic [1:0]  kind_q;
	logic [63:0] key_q;
	logic [1:0]  typ_q;
	logic [15:0] par_q;
	logic [CW-1:0] cls_q;
	logic [7:0]  slots_q;
	logic [2:0]  flags_q;

	// sweep state
	logic [AW:0]   rd_ptr_q;   // read address counter (one beyond depth)
	logic          rd_vld_s1;  // a row read is in flight
	logic [AW-1:0] rd_idx_s1;
	logic          found_q;
	logic [AW-1:0] hit_idx_q;
	mtrg_pkg::row_t hit_row_q; // copy of the row holding the key
	logic          free_q;
	logic [AW-1:0] free_idx_q;
	logic [NW-1:0] removed_q;

	logic [31:0] gauge_q [RESOURCE_CLASSES];
	logic [31:0] seq_q;
	logic [NW-1:0] rows_q;
	logic [CW:0]   sum_idx_q;
	logic [31:0]   sum_q;
	logic [1:0]    status_q;

	// row memory
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	mtrg_pkg::row_t           ram_wdata;
	logic [mtrg_pkg::ROW_W-1:0] ram_rdata;
	mtrg_pkg::row_t           row_rd;

	mtrg_ram #(
		.WIDTH(mtrg_pkg::ROW_W),
		.DEPTH(TABLE_ENTRIES)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_ptr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign row_rd = mtrg_pkg::row_t'(ram_rdata);

	// class index folding, a 16-entry lookup
	function automatic logic [CW-1:0] fold_class(input logic [3:0] c);
		logic [CW-1:0] r;
		r = '0;
		for (int v = 0; v < 16; v++) begin
			if (c == 4'(v)) r = CW'(v % RESOURCE_CLASSES);
		end
		return r;
	endfunction

	// match tests on the row that just came back from memory
	logic row_live, key_hit, flush_hit;
	logic [CW-1:0] row_cls, hit_cls;
	always_comb begin
		row_live  = rd_vld_s1 && row_rd.valid;
		key_hit   = row_live && (row_rd.key == key_q);
		flush_hit = row_live
			&& (!flags_q[0] || row_rd.key[15:0] == key_q[15:0])
			&& (!flags_q[1] || row_rd.etype == typ_q)
			&& (!flags_q[2] || row_rd.eparam == par_q);
		row_cls   = row_rd.rclass[CW-1:0];
		hit_cls   = hit_row_q.rclass[CW-1:0];
	end

	// write port: clearing pass, flush removals, then update/delete in S_DO
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = found_q ? hit_idx_q : free_idx_q;
		ram_wdata = hit_row_q;
		if (state_q == S_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = rd_ptr_q[AW-1:0];
			ram_wdata = '0;
		end else if (state_q == S_SCAN) begin
			ram_waddr       = rd_idx_s1;
			ram_wdata       = row_rd;
			ram_wdata.valid = 1'b0;
			ram_we          = (kind_q == mtrg_pkg::KIND_FLUSH) && flush_hit;
		end else if (state_q == S_DO) begin
			if (kind_q == mtrg_pkg::KIND_UPDATE) begin
				if (found_q) begin
					ram_wdata.etype  = typ_q;
					ram_wdata.eparam = par_q;
					ram_we           = 1'b1;
				end else if (free_q) begin
					ram_wdata.valid  = 1'b1;
					ram_wdata.key    = key_q;
					ram_wdata.etype  = typ_q;
					ram_wdata.eparam = par_q;
					ram_wdata.rclass = 6'(cls_q);
					ram_wdata.slots  = slots_q;
					ram_we           = 1'b1;
				end
			end else if (kind_q == mtrg_pkg::KIND_DELETE && found_q) begin
				ram_wdata.valid = 1'b0;
				ram_we          = 1'b1;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status          = status_q;
	assign gauge_value     = gauge_q[cls_q];
	assign gauge_total     = sum_q;
	assign sequence_number = seq_q;
	assign row_count       = 11'(rows_q);
	assign removed_count   = 11'(removed_q);

	// payload capture
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_q  <= kind;
			key_q   <= {mac_address, filter_id};
			typ_q   <= entry_type;
			par_q   <= entry_param;
			cls_q   <= fold_class(resource_class);
			slots_q <= slot_count;
			flags_q <= match_flags;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			rd_ptr_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			found_q    <= 1'b0;
			hit_idx_q  <= '0;
			hit_row_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			removed_q  <= '0;
			seq_q      <= '0;
			rows_q     <= '0;
			sum_idx_q  <= '0;
			sum_q      <= '0;
			status_q   <= mtrg_pkg::ST_OK;
			for (int c = 0; c < RESOURCE_CLASSES; c++) begin
				gauge_q[c] <= '0;
			end
		end else begin
			unique case (state_q)
				S_CLR: begin
					// zero one memory row per cycle
					if (rd_ptr_q == (AW+1)'(TABLE_ENTRIES - 1)) begin
						state_q  <= S_IDLE;
						rd_ptr_q <= '0;
					end else begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q   <= S_SCAN;
						rd_ptr_q  <= '0;
						rd_vld_s1 <= 1'b0;
						found_q   <= 1'b0;
						free_q    <= 1'b0;
						removed_q <= '0;
						status_q  <= mtrg_pkg::ST_OK;
					end
				end
				S_SCAN: begin
					// issue next read
					rd_vld_s1 <= (rd_ptr_q < (AW+1)'(TABLE_ENTRIES));
					rd_idx_s1 <= rd_ptr_q[AW-1:0];
					if (rd_ptr_q < (AW+1)'(TABLE_ENTRIES)) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					// examine returned row
					if (rd_vld_s1) begin
						if (!row_rd.valid && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
						if (key_hit && !found_q) begin
							found_q   <= 1'b1;
							hit_idx_q <= rd_idx_s1;
							hit_row_q <= row_rd;
						end
						if (kind_q == mtrg_pkg::KIND_FLUSH && flush_hit) begin
							gauge_q[row_cls] <= gauge_q[row_cls] - 32'(row_rd.slots);
							seq_q     <= seq_q + 1'b1;
							rows_q    <= rows_q - 1'b1;
							removed_q <= removed_q + 1'b1;
						end
					end
					if (!rd_vld_s1 && rd_ptr_q == (AW+1)'(TABLE_ENTRIES)) begin
						state_q <= S_DO;
					end
				end
				S_DO: begin
					// apply update or delete using the captured hit row
					if (kind_q == mtrg_pkg::KIND_UPDATE) begin
						if (found_q) begin
							seq_q <= seq_q + 1'b1;
						end else if (free_q) begin
							gauge_q[cls_q] <= gauge_q[cls_q] + 32'(slots_q);
							seq_q  <= seq_q + 1'b1;
							rows_q <= rows_q + 1'b1;
						end else begin
							status_q <= mtrg_pkg::ST_FULL;
						end
					end else if (kind_q == mtrg_pkg::KIND_DELETE) begin
						if (found_q) begin
							gauge_q[hit_cls] <= gauge_q[hit_cls] - 32'(hit_row_q.slots);
							seq_q     <= seq_q + 1'b1;
							rows_q    <= rows_q - 1'b1;
							removed_q <= NW'(1);
						end else begin
							status_q <= mtrg_pkg::ST_NOT_FOUND;
						end
					end
					state_q   <= S_SUM;
					sum_idx_q <= '0;
					sum_q     <= '0;
				end
				S_SUM: begin
					// running total, one gauge per cycle
					if (sum_idx_q == (CW+1)'(RESOURCE_CLASSES)) begin
						state_q <= S_OUT;
					end else begin
						sum_q     <= sum_q + gauge_q[sum_idx_q[CW-1:0]];
						sum_idx_q <= sum_idx_q + 1'b1;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= NW'(TABLE_ENTRIES))
		else $error("row count beyond table depth");
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("response shown while accepting");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sum_q) && $stable(seq_q))
		else $error("response changed under stall");
	a_gauge_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DO && kind_q == mtrg_pkg::KIND_GAUGE |=> $stable(seq_q))
		else $error("gauge read changed the table");
`endif

endmodule

### sv/mtrg_ram.sv
// ---------------------------------------------------------------------------
// mtrg_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module mtrg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sim/mtrg_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtrg_checker
// Watches both channels of the MAC table, predicts each response from a
// private copy of the table, gauges and counters, and compares field by field.
// ---------------------------------------------------------------------------
module mtrg_checker #(
	parameter int TABLE_ENTRIES    = 1024,
	parameter int RESOURCE_CLASSES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [47:0] mac_address,
	input  logic [15:0] filter_id,
	input  logic [1:0]  entry_type,
	input  logic [15:0] entry_param,
	input  logic [3:0]  resource_class,
	input  logic [7:0]  slot_count,
	input  logic [2:0]  match_flags,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [31:0] gauge_value,
	input  logic [31:0] gauge_total,
	input  logic [31:0] sequence_number,
	input  logic [10:0] row_count,
	input  logic [10:0] removed_count,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] gauge;
		logic [31:0] total;
		logic [31:0] seqno;
		logic [10:0] rows;
		logic [10:0] removed;
	} resp_t;

	// shadow table
	bit          shadow_valid [TABLE_ENTRIES];
	logic [63:0] shadow_key   [TABLE_ENTRIES];
	logic [1:0]  shadow_type  [TABLE_ENTRIES];
	logic [15:0] shadow_param [TABLE_ENTRIES];
	int          shadow_class [TABLE_ENTRIES];
	logic [7:0]  shadow_slots [TABLE_ENTRIES];
	logic [31:0] shadow_gauge [RESOURCE_CLASSES];
	logic [31:0] shadow_seq;
	logic [10:0] shadow_rows;
	resp_t       expected_resp [$];

	assign pending = expected_resp.size();

	// remove one row from the shadow table
	function automatic void drop_row(int i);
		shadow_gauge[shadow_class[i]] -= 32'(shadow_slots[i]);
		shadow_valid[i] = 0;
		shadow_rows--;
		shadow_seq++;
	endfunction

	// apply one request to the shadow state and return its response
	function automatic resp_t apply_request();
		resp_t       r;
		logic [63:0] k;
		int          cls, hit, free_row;
		k = {mac_address, filter_id};
		cls = int'(resource_class) % RESOURCE_CLASSES;
		r = '0;
		r.status = mtrg_pkg::ST_OK;
		hit = -1;
		free_row = -1;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (shadow_valid[i] && shadow_key[i] == k) hit = i;
			if (!shadow_valid[i]) free_row = i;
		end
		case (kind)
			mtrg_pkg::KIND_UPDATE: begin
				if (hit >= 0) begin
					shadow_type[hit] = entry_type;
					shadow_param[hit] = entry_param;
					shadow_seq++;
				end else if (free_row < 0) begin
					r.status = mtrg_pkg::ST_FULL;
				end else begin
					shadow_valid[free_row] = 1;
					shadow_key[free_row] = k;
					shadow_type[free_row] = entry_type;
					shadow_param[free_row] = entry_param;
					shadow_class[free_row] = cls;
					shadow_slots[free_row] = slot_count;
					shadow_gauge[cls] += 32'(slot_count);
					shadow_rows++;
					shadow_seq++;
				end
			end
			mtrg_pkg::KIND_DELETE: begin
				if (hit < 0) begin
					r.status = mtrg_pkg::ST_NOT_FOUND;
				end else begin
					drop_row(hit);
					r.removed = 1;
				end
			end
			mtrg_pkg::KIND_FLUSH: begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (!shadow_valid[i]) continue;
					if (match_flags[0] && shadow_key[i][15:0] != filter_id) continue;
					if (match_flags[1] && shadow_type[i] != entry_type) continue;
					if (match_flags[2] && shadow_param[i] != entry_param) continue;
					drop_row(i);
					r.removed++;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < RESOURCE_CLASSES; i++) r.total += shadow_gauge[i];
		r.gauge = shadow_gauge[cls];
		r.seqno = shadow_seq;
		r.rows = shadow_rows;
		return r;
	endfunction

	// predict on accepted requests, compare on accepted responses
	always @(posedge clk or negedge arst_n) begin
		resp_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) shadow_valid[i] = 0;
			for (int i = 0; i < RESOURCE_CLASSES; i++) shadow_gauge[i] = '0;
			shadow_seq = '0;
			shadow_rows = '0;
			expected_resp.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_resp.size() == 0) begin
					$display("%t: response with none expected (status %0d)", $time, status);
					fail_count++;
				end else begin
					want = expected_resp.pop_front();
					if (status !== want.status) begin
						$display("%t: status exp %0d got %0d", $time, want.status, status);
						fail_count++;
					end
					if (gauge_value !== want.gauge) begin
						$display("%t: gauge_value exp %0d got %0d", $time, want.gauge,
							gauge_value);
						fail_count++;
					end
					if (gauge_total !== want.total) begin
						$display("%t: gauge_total exp %0d got %0d", $time, want.total,
							gauge_total);
						fail_count++;
					end
					if (sequence_number !== want.seqno) begin
						$display("%t: sequence_number exp %0d got %0d", $time, want.seqno,
							sequence_number);
						fail_count++;
					end
					if (row_count !== want.rows) begin
						$display("%t: row_count exp %0d got %0d", $time, want.rows, row_count);
						fail_count++;
					end
					if (removed_count !== want.removed) begin
						$display("%t: removed_count exp %0d got %0d", $time, want.removed,
							removed_count);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) expected_resp.push_back(apply_request());
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives update, delete, flush and gauge read requests into the MAC table,
// with random idling on both channels; a checker predicts the responses.
// ---------------------------------------------------------------------------
module testbench;

	localparam int N_ROWS     = 1024;
	localparam int N_CLASSES  = 16;
	localparam int N_RANDOM   = 510;
	localparam int IDLE_LIMIT = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  kind = mtrg_pkg::KIND_GAUGE;
	logic [47:0] mac_address = '0;
	logic [15:0] filter_id = '0;
	logic [1:0]  entry_type = '0;
	logic [15:0] entry_param = '0;
	logic [3:0]  resource_class = '0;
	logic [7:0]  slot_count = '0;
	logic [2:0]  match_flags = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  status;
	logic [31:0] gauge_value, gauge_total, sequence_number;
	logic [10:0] row_count, removed_count;
	int          fail_count, pending;
	int          idle_cycles = 0;
	int          stall_left = 0;
	bit          quiet_tail = 0;
	bit          finished = 0;

	// a small pool of keys so deletes and rewrites hit existing rows
	logic [47:0] mac_pool [8];
	logic [15:0] fid_pool [4];

	always #6 clk = ~clk;

	mac_table_with_resource_gauges #(
		.TABLE_ENTRIES(N_ROWS),
		.RESOURCE_CLASSES(N_CLASSES)
	) u_dut (.*);

	mtrg_checker #(
		.TABLE_ENTRIES(N_ROWS),
		.RESOURCE_CLASSES(N_CLASSES)
	) u_checker (.*);

	// send one request and wait for its acceptance, sometimes with a random gap first
	task automatic send_request(input logic [1:0] k, input logic [47:0] mac,
		input logic [15:0] fid, input logic [1:0] et, input logic [15:0] ep,
		input logic [3:0] rc, input logic [7:0] sc, input logic [2:0] mf);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		kind <= k;
		mac_address <= mac;
		filter_id <= fid;
		entry_type <= et;
		entry_param <= ep;
		resource_class <= rc;
		slot_count <= sc;
		match_flags <= mf;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
	endtask

	// random request with mostly pooled keys
	task automatic send_random();
		logic [1:0]  k;
		logic [47:0] mac;
		logic [15:0] fid;
		int          p;
		p = $urandom_range(0, 99);
		if (p < 50) k = mtrg_pkg::KIND_UPDATE;
		else if (p < 80) k = mtrg_pkg::KIND_DELETE;
		else if (p < 88) k = mtrg_pkg::KIND_FLUSH;
		else k = mtrg_pkg::KIND_GAUGE;
		if ($urandom_range(0, 9) < 8) begin
			mac = mac_pool[$urandom_range(0, 7)];
			fid = fid_pool[$urandom_range(0, 3)];
		end else begin
			mac = 48'({$urandom, $urandom});
			fid = 16'($urandom);
		end
		send_request(k, mac, fid, 2'($urandom), 16'($urandom_range(0, 3)),
			4'($urandom), 8'($urandom), 3'($urandom));
	endtask

	// receiver stall in random bursts
	always @(posedge clk) begin
		if (quiet_tail) begin
			out_stall <= 0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1;
			stall_left <= int'($urandom_range(0, 5));
		end else begin
			out_stall <= 0;
		end
	end

	// watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT && !finished) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 8; i++) mac_pool[i] = 48'({$urandom, $urandom});
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		for (int i = 0; i < 4; i++) fid_pool[i] = 16'($urandom);
		fid_pool[0] = '0;
		fid_pool[1] = '1;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, rewrite, missing delete, flushes
		send_request(mtrg_pkg::KIND_GAUGE, '0, '0, 2'd0, '0, 4'd0, 8'd0, 3'd0);
		send_request(mtrg_pkg::KIND_UPDATE, '0, '0, 2'd0, '0, 4'd0, 8'd0, 3'd0);
		send_request(mtrg_pkg::KIND_UPDATE, '1, '1, 2'd3, '1, 4'd15, 8'd255, 3'd7);
		send_request(mtrg_pkg::KIND_UPDATE, '1, '1, 2'd1, 16'h1234, 4'd3, 8'd9, 3'd0);
		send_request(mtrg_pkg::KIND_UPDATE, '1, '0, 2'd2, 16'h1234, 4'd15, 8'd255, 3'd0);
		send_request(mtrg_pkg::KIND_GAUGE, '0, '0, 2'd0, '0, 4'd15, 8'd0, 3'd0);
		send_request(mtrg_pkg::KIND_DELETE, 48'h123, 16'h5, 2'd0, '0, 4'd15, 8'd0, 3'd0);
		send_request(mtrg_pkg::KIND_DELETE, '0, '0, 2'd0, '0, 4'd0, 8'd0, 3'd0);
		send_request(mtrg_pkg::KIND_FLUSH, '0, '1, 2'd0, '0, 4'd15, 8'd0, 3'b001);
		send_request(mtrg_pkg::KIND_FLUSH, '0, '0, 2'd2, '0, 4'd15, 8'd0, 3'b010);
		send_request(mtrg_pkg::KIND_FLUSH, '0, '0, 2'd0, 16'h1234, 4'd15, 8'd0, 3'b100);
		send_request(mtrg_pkg::KIND_UPDATE, 48'h5, 16'h7, 2'd1, 16'h9, 4'd2, 8'd100, 3'd0);
		send_request(mtrg_pkg::KIND_UPDATE, 48'h6, 16'h7, 2'd1, 16'h8, 4'd2, 8'd200, 3'd0);
		send_request(mtrg_pkg::KIND_FLUSH, '0, 16'h7, 2'd1, 16'h9, 4'd2, 8'd0, 3'b111);
		send_request(mtrg_pkg::KIND_FLUSH, '0, '0, 2'd0, '0, 4'd2, 8'd0, 3'b000);
		send_request(mtrg_pkg::KIND_FLUSH, '0, '0, 2'd0, '0, 4'd2, 8'd0, 3'b000);
		// fill the table with 255-slot rows, then hit table full
		for (int i = 0; i < N_ROWS; i++)
			send_request(mtrg_pkg::KIND_UPDATE, 48'(i) + 48'h1000, 16'(i), 2'(i), 16'(i),
				4'(i), 8'd255, 3'd0);
		send_request(mtrg_pkg::KIND_UPDATE, 48'hABCDEF, 16'h1, 2'd0, '0, 4'd1, 8'd1, 3'd0);
		send_request(mtrg_pkg::KIND_UPDATE, 48'h1000, 16'h0, 2'd3, 16'h77, 4'd1, 8'd1, 3'd0);
		send_request(mtrg_pkg::KIND_FLUSH, '0, '0, 2'd0, '0, 4'd0, 8'd0, 3'b000);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n > N_RANDOM - 150) quiet_tail = 1;
			send_random();
		end
		@(posedge clk);
		in_valid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (N_ROWS + N_CLASSES + 20) @(posedge clk);
		finished = 1;
		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
